### design/tsm_pkg.sv
`default_nettype none

package tsm_pkg;

	// defaults for the top-level parameters
	localparam int GROUP_SIZE_DEF  = 10;
	localparam int SAMPLE_BITS_DEF = 12;

	// sorted positions that enter the mean
	localparam int TRIM_FIRST = 3;
	localparam int TRIM_COUNT = 3;

	// status of the queue between front and back
	typedef struct packed {
		logic full;
		logic empty;
	} tsm_qstat_t;

endpackage

`default_nettype wire

### design/tsm_front.sv
`default_nettype none

module tsm_front
	import tsm_pkg::*;
#(
	parameter int GROUP_SIZE  = GROUP_SIZE_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              push,
	output logic                                   full,
	input  wire logic [SAMPLE_BITS-1:0]            sample,
	input  wire tsm_qstat_t                        qstat,
	output logic                                   q_push,
	output logic [TRIM_COUNT*SAMPLE_BITS-1:0]      q_data
);

	localparam int CW = $clog2(GROUP_SIZE);

	logic [SAMPLE_BITS-1:0] cell_q [GROUP_SIZE];
	logic [SAMPLE_BITS-1:0] nxt [GROUP_SIZE];
	logic [GROUP_SIZE-1:0]  gt;
	logic [CW-1:0]          count_q;
	logic                   accept;
	logic                   last;

	// hold off while the queue has no room for a finished group
	assign full   = qstat.full;
	assign accept = push && !full;
	assign last   = (count_q == CW'(GROUP_SIZE - 1));

	// find cells above the new word; unfilled cells count as above everything
	always_comb begin
		for (int i = 0; i < GROUP_SIZE; i++) begin
			gt[i] = (CW'(i) >= count_q) || (cell_q[i] > sample);
		end
	end

	// insert the new word, shift the larger ones up by one
	always_comb begin
		for (int i = 0; i < GROUP_SIZE; i++) begin
			if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
				nxt[i] = cell_q[(i > 0) ? i - 1 : 0];
			end else if (gt[i]) begin
				nxt[i] = sample;
			end else begin
				nxt[i] = cell_q[i];
			end
		end
	end

	// hand the middle positions of a complete group to the queue
	always_comb begin
		for (int j = 0; j < TRIM_COUNT; j++) begin
			q_data[j*SAMPLE_BITS +: SAMPLE_BITS] = nxt[TRIM_FIRST + j];
		end
	end
	assign q_push = accept && last;

	// store sorted cells
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < GROUP_SIZE; i++) begin
				cell_q[i] <= nxt[i];
			end
		end
	end

	// advance the fill count, wrap at the end of a group
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= last ? '0 : count_q + 1'b1;
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, count_q} < (CW+1)'(GROUP_SIZE)) else $error("fill count out of range");

	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |=> count_q == '0) else $error("fill count did not wrap");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !qstat.full) else $error("queue written while full");

endmodule

`default_nettype wire

### design/tsm_queue.sv
`default_nettype none

module tsm_queue
	import tsm_pkg::*;
#(
	parameter int WIDTH = TRIM_COUNT * SAMPLE_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	output logic      [WIDTH-1:0] rd_data,
	output tsm_qstat_t            qstat
);

	logic [WIDTH-1:0] ent_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign qstat.full  = (cnt_q == 2'd2);
	assign qstat.empty = (cnt_q == 2'd0);
	assign do_wr       = wr_en && !qstat.full;
	assign do_rd       = rd_en && !qstat.empty;
	assign rd_data     = ent_q[rd_ptr_q];

	// store one word
	always_ff @(posedge clk) begin
		if (do_wr) begin
			ent_q[wr_ptr_q] <= wr_data;
		end
	end

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_count_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue occupancy out of range");

	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 || cnt_q == 2'd2) |-> wr_ptr_q == rd_ptr_q)
		else $error("queue pointers disagree with occupancy");

	a_ptr_split: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd1 |-> wr_ptr_q != rd_ptr_q)
		else $error("queue pointers disagree with occupancy");

endmodule

`default_nettype wire

### design/tsm_back.sv
`default_nettype none

module tsm_back
	import tsm_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire tsm_qstat_t                        qstat,
	input  wire logic [TRIM_COUNT*SAMPLE_BITS-1:0] q_data,
	output logic                                   q_pop,
	input  wire logic                              pop,
	output logic                                   empty,
	output logic [SAMPLE_BITS-1:0]                 filtered
);

	localparam int SW = SAMPLE_BITS + 2;
	localparam int K  = SW + 2;
	localparam logic [K-1:0] RECIP = K'((2 ** K) / TRIM_COUNT);

	logic                   adv;
	logic                   v_s1;
	logic                   v_s2;
	logic                   out_v_q;
	logic [SW-1:0]          sum_s1;
	logic [SW-1:0]          sum_s2;
	logic [SW-1:0]          quot_s2;
	logic [SW-1:0]          sum_in;
	logic [SW+K-1:0]        prod;
	logic [SW+1:0]          three_q;
	logic [SW+1:0]          rem;
	logic [SW-1:0]          quot_fix;
	logic [SAMPLE_BITS-1:0] out_q;

	// move the whole pipe when the output slot frees
	assign adv   = !out_v_q || pop;
	assign q_pop = adv && !qstat.empty;

	// add the middle three sorted words
	always_comb begin
		sum_in = '0;
		for (int j = 0; j < TRIM_COUNT; j++) begin
			sum_in = sum_in + SW'(q_data[j*SAMPLE_BITS +: SAMPLE_BITS]);
		end
	end

	// estimate the quotient by the reciprocal, low by at most one
	assign prod = SW'(sum_s1) * RECIP;

	// correct the estimate with one compare
	assign three_q  = (SW+2)'(quot_s2) * (SW+2)'(TRIM_COUNT);
	assign rem      = (SW+2)'(sum_s2) - three_q;
	assign quot_fix = (rem >= (SW+2)'(TRIM_COUNT)) ? quot_s2 + 1'b1 : quot_s2;

	// payload stages
	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s1  <= sum_in;
			sum_s2  <= sum_s1;
			quot_s2 <= prod[K +: SW];
			out_q   <= quot_fix[SAMPLE_BITS-1:0];
		end
	end

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			v_s1    <= !qstat.empty;
			v_s2    <= v_s1;
			out_v_q <= v_s2;
		end
	end

	assign empty    = !out_v_q;
	assign filtered = out_q;

	a_quot_exact: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (three_q <= (SW+2)'(sum_s2)) && (rem < (SW+2)'(2 * TRIM_COUNT)))
		else $error("reciprocal estimate off by more than one");

	a_pop_source: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> adv) else $error("queue read while pipe stalled");

endmodule

`default_nettype wire

### design/touch_sample_trimmed_mean.sv
// A closed group enters the queue, then the sum, estimate and result registers.
// Throughput: one sample per cycle while the queue is not full; one result per group.
// The rate is set by the insertion sorter, which places each sample on arrival.
// Reset clears the fill count, the queue occupancy and the pipe valid flags;
// the sorter cells hold no reset value and are rewritten by every group.
`default_nettype none

module touch_sample_trimmed_mean
	import tsm_pkg::*;
#(
	parameter int GROUP_SIZE  = GROUP_SIZE_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	output logic                        full,
	input  wire logic [SAMPLE_BITS-1:0] sample,
	output logic                        empty,
	input  wire logic                   pop,
	output logic      [SAMPLE_BITS-1:0] filtered
);

	localparam int QW = TRIM_COUNT * SAMPLE_BITS;

	tsm_qstat_t    qstat;
	logic          q_push;
	logic          q_pop;
	logic [QW-1:0] q_wdata;
	logic [QW-1:0] q_rdata;

	// sort samples as they arrive
	tsm_front #(
		.GROUP_SIZE  (GROUP_SIZE),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.sample (sample),
		.qstat  (qstat),
		.q_push (q_push),
		.q_data (q_wdata)
	);

	// hold finished groups
	tsm_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wdata),
		.rd_en   (q_pop),
		.rd_data (q_rdata),
		.qstat   (qstat)
	);

	// average the middle words
	tsm_back #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.qstat    (qstat),
		.q_data   (q_rdata),
		.q_pop    (q_pop),
		.pop      (pop),
		.empty    (empty),
		.filtered (filtered)
	);

endmodule

`default_nettype wire

### dv/tb_touch_sample_trimmed_mean.sv
`default_nettype none

module tb_touch_sample_trimmed_mean;
	import tsm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int GROUP_SIZE  = GROUP_SIZE_DEF;
	localparam int SAMPLE_BITS = SAMPLE_BITS_DEF;
	localparam int MAX_SAMPLE  = (1 << SAMPLE_BITS) - 1;
	localparam int RAND_ITEMS  = 1650;
	localparam int DIR_ROWS    = 25;
	localparam int PIPE_DELAY  = 3;
	localparam int HOLD_CYCLES = 1000;
	localparam int HOLD_AFTER  = 400;
	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_REPORTS = 10;

	typedef logic [SAMPLE_BITS-1:0] sample_t;

	// one row of the directed table; want is only used where typed is set
	typedef struct packed {
		sample_t smp;
		logic    typed;
		sample_t want;
	} dir_row_t;

	logic    clk    = 1'b0;
	logic    arst_n = 1'b0;
	logic    push   = 1'b0;
	logic    pop    = 1'b0;
	sample_t sample = '0;
	logic    full;
	logic    empty;
	sample_t filtered;

	// a group of zeros, a group at full scale, then mixed extremes that the
	// random part completes
	dir_row_t dir_tab [DIR_ROWS] = '{
		'{12'h000, 1'b0, 12'h000}, '{12'h000, 1'b0, 12'h000}, '{12'h000, 1'b0, 12'h000},
		'{12'h000, 1'b0, 12'h000}, '{12'h000, 1'b0, 12'h000}, '{12'h000, 1'b0, 12'h000},
		'{12'h000, 1'b0, 12'h000}, '{12'h000, 1'b0, 12'h000}, '{12'h000, 1'b0, 12'h000},
		'{12'h000, 1'b1, 12'h000},
		'{12'hFFF, 1'b0, 12'h000}, '{12'hFFF, 1'b0, 12'h000}, '{12'hFFF, 1'b0, 12'h000},
		'{12'hFFF, 1'b0, 12'h000}, '{12'hFFF, 1'b0, 12'h000}, '{12'hFFF, 1'b0, 12'h000},
		'{12'hFFF, 1'b0, 12'h000}, '{12'hFFF, 1'b0, 12'h000}, '{12'hFFF, 1'b0, 12'h000},
		'{12'hFFF, 1'b1, 12'hFFF},
		'{12'hAAA, 1'b0, 12'h000}, '{12'h555, 1'b0, 12'h000}, '{12'hFFF, 1'b0, 12'h000},
		'{12'h000, 1'b0, 12'h000}, '{12'h800, 1'b0, 12'h000}
	};

	// predictor state
	sample_t group_buf [GROUP_SIZE];
	int      group_fill = 0;
	sample_t trim_mean_q [$];

	// stimulus state and run statistics
	sample_t touch_base  = '0;
	sample_t last_sample = '0;
	int      n_items     = 0;
	int      n_results   = 0;
	int      n_full      = 0;
	int      n_errors    = 0;
	int      n_cycles    = 0;

	touch_sample_trimmed_mean #(
		.GROUP_SIZE (GROUP_SIZE),
		.SAMPLE_BITS(SAMPLE_BITS)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.sample  (sample),
		.empty   (empty),
		.pop     (pop),
		.filtered(filtered)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// count a failure, print only the first few
	task automatic note_error(input string msg);
		n_errors++;
		if (n_errors <= MAX_REPORTS) begin
			$display("ERROR @%0t: %s", $realtime, msg);
		end
	endtask

	// mean of the three middle sorted entries, truncated
	function automatic sample_t trimmed_mean(input sample_t grp [GROUP_SIZE]);
		sample_t ord [GROUP_SIZE];
		sample_t key;
		int      k;
		int      sum;
		ord = grp;
		for (int i = 1; i < GROUP_SIZE; i++) begin
			key = ord[i];
			k = i;
			while (k > 0 && ord[k-1] > key) begin
				ord[k] = ord[k-1];
				k--;
			end
			ord[k] = key;
		end
		sum = 0;
		for (int i = TRIM_FIRST; i < TRIM_FIRST + TRIM_COUNT; i++) begin
			sum += ord[i];
		end
		return sample_t'(sum / TRIM_COUNT);
	endfunction

	// add one word to the current group; report the mean when the group closes
	task automatic absorb_sample(input sample_t s, output bit done, output sample_t mean);
		group_buf[group_fill] = s;
		group_fill++;
		done = 1'b0;
		mean = '0;
		if (group_fill == GROUP_SIZE) begin
			group_fill = 0;
			done = 1'b1;
			mean = trimmed_mean(group_buf);
		end
	endtask

	// hold the word on the input until the block takes it
	task automatic offer(input sample_t v);
		push   <= 1'b1;
		sample <= v;
		@(posedge clk);
		while (full) @(posedge clk);
		n_items++;
	endtask

	// mix of full-range noise, clustered readings, repeats and extremes
	function automatic sample_t pick_sample();
		int v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				v = $urandom_range(0, MAX_SAMPLE);
			end
			4, 5: begin
				v = int'(touch_base) + $urandom_range(0, 64) - 32;
				if (v < 0) v = 0;
				if (v > MAX_SAMPLE) v = MAX_SAMPLE;
			end
			6: begin
				v = $urandom_range(0, 1) ? MAX_SAMPLE : 0;
			end
			7: begin
				v = last_sample;
			end
			8: begin
				v = $urandom_range(0, 15);
			end
			default: begin
				v = $urandom_range(MAX_SAMPLE - 15, MAX_SAMPLE);
			end
		endcase
		return sample_t'(v);
	endfunction

	// check each result word against the oldest prediction
	always @(posedge clk) begin : result_check
		sample_t want;
		if (arst_n && push && full) n_full++;
		if (arst_n && pop && !empty) begin
			if (trim_mean_q.size() == 0) begin
				note_error($sformatf("result %0d with no prediction waiting", filtered));
			end else begin
				want = trim_mean_q.pop_front();
				n_results++;
				if (filtered !== want) begin
					note_error($sformatf("filtered: expected %0d, got %0d", want, filtered));
				end
			end
		end
	end

	// give up on a hung run
	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", n_cycles);
			$display("touch_sample_trimmed_mean test failed");
			$finish;
		end
	end

	// drain side: segments of random pop patterns, one long hold-off
	initial begin : drain_side
		int  seg;
		int  mode;
		bit  held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && n_items >= HOLD_AFTER) begin
				held = 1'b1;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			seg  = $urandom_range(10, 150);
			mode = $urandom_range(0, 3);
			repeat (seg) begin
				case (mode)
					0: begin
						pop <= 1'b1;
					end
					1: begin
						pop <= $urandom_range(0, 1);
					end
					2: begin
						pop <= ($urandom_range(0, 3) == 0);
					end
					default: begin
						pop <= ($urandom_range(0, 7) != 0);
					end
				endcase
				@(posedge clk);
			end
		end
	end

	// feed side: directed table, then random bursts
	initial begin : feed_side
		bit      done;
		sample_t mean;
		sample_t s;
		int      burst_left;
		int      gap;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table
		foreach (dir_tab[i]) begin
			offer(dir_tab[i].smp);
			absorb_sample(dir_tab[i].smp, done, mean);
			if (done) trim_mean_q.push_back(dir_tab[i].typed ? dir_tab[i].want : mean);
		end

		// random words in bursts with gaps
		burst_left = 0;
		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (burst_left == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				if (gap > 0) begin
					push <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst_left = ($urandom_range(0, 9) == 0) ? 100 : $urandom_range(1, 30);
			end
			if (group_fill == 0) touch_base = $urandom_range(0, MAX_SAMPLE);
			s = pick_sample();
			last_sample = s;
			offer(s);
			absorb_sample(s, done, mean);
			if (done) trim_mean_q.push_back(mean);
			burst_left--;
		end
		push <= 1'b0;

		// wait for the last results, then check for strays
		wait (trim_mean_q.size() == 0);
		repeat (PIPE_DELAY + 20) @(posedge clk);
		if (trim_mean_q.size() != 0) begin
			note_error($sformatf("%0d predicted results never arrived", trim_mean_q.size()));
		end

		$display("sent %0d samples, checked %0d trimmed means, %0d errors",
			n_items, n_results, n_errors);
		$display("input held off by full on %0d cycles during back-pressure", n_full);
		if (n_errors == 0) begin
			$display("touch_sample_trimmed_mean test passed");
		end else begin
			$display("touch_sample_trimmed_mean test failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

### filelist.f
design/tsm_pkg.sv
design/tsm_front.sv
design/tsm_queue.sv
design/tsm_back.sv
design/touch_sample_trimmed_mean.sv
dv/tb_touch_sample_trimmed_mean.sv
